/* sv/greedy_rectangle_cover_extractor_core_assert.svh */
// assertion macros for the rectangle extractor
`ifndef GREEDY_RECTANGLE_COVER_EXTRACTOR_CORE_ASSERT_SVH
`define GREEDY_RECTANGLE_COVER_EXTRACTOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define GRC_ASSERT_IMP(lbl, ante, cons) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |-> (cons)) else $error("grc assertion failed");
`define GRC_ASSERT_NXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |=> (cons)) else $error("grc assertion failed");
`else
`define GRC_ASSERT_IMP(lbl, ante, cons)
`define GRC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* sv/grc_pkg.sv */
package grc_pkg;

    localparam logic CFG_ACTIVE_COLUMNS = 1'b0;
    localparam logic CFG_ACTIVE_ROWS    = 1'b1;
    localparam logic MODE_LOAD          = 1'b0;
    localparam logic MODE_EXTRACT       = 1'b1;
    localparam logic [6:0] HEIGHT_MAX   = 7'd127;

    typedef struct packed {
        logic init;
        logic load;
        logic row_rd;
        logic height;
        logic inner_load;
        logic inner_step;
        logic outer_next;
        logic row_next;
        logic clr_start;
        logic clr_rd;
        logic clr_wr;
    } grc_cmd_t;

    typedef struct packed {
        logic empty_area;
        logic outer_end;
        logic depth_new;
        logic row_last;
        logic inner_end;
        logic found;
        logic clr_last;
    } grc_sts_t;

endpackage

/* sv/grc_ctrl.sv */
module grc_ctrl
    import grc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     mode,
    input  grc_sts_t sts,
    output grc_cmd_t cmd,
    output logic     busy,
    output logic     done
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_RD_ROW = 8'b0000_0010,
        ST_HEIGHT = 8'b0000_0100,
        ST_OUTER  = 8'b0000_1000,
        ST_INNER  = 8'b0001_0000,
        ST_CLR_RD = 8'b0010_0000,
        ST_CLR_WR = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode == MODE_EXTRACT)
                    begin
                        cmd.init   = 1'b1;
                        state_next = sts.empty_area ? ST_DONE : ST_RD_ROW;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_RD_ROW:
            begin
                cmd.row_rd = 1'b1;
                state_next = ST_HEIGHT;
            end
            ST_HEIGHT:
            begin
                cmd.height = 1'b1;
                state_next = ST_OUTER;
            end
            ST_OUTER:
            begin
                if (sts.outer_end)
                begin
                    if (!sts.row_last)
                    begin
                        cmd.row_next = 1'b1;
                        state_next   = ST_RD_ROW;
                    end
                    else if (sts.found)
                    begin
                        cmd.clr_start = 1'b1;
                        state_next    = ST_CLR_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (sts.depth_new)
                begin
                    cmd.inner_load = 1'b1;
                    state_next     = ST_INNER;
                end
                else
                begin
                    cmd.outer_next = 1'b1;
                end
            end
            ST_INNER:
            begin
                cmd.inner_step = 1'b1;
                if (sts.inner_end)
                begin
                    cmd.outer_next = 1'b1;
                    state_next     = ST_OUTER;
                end
            end
            ST_CLR_RD:
            begin
                cmd.clr_rd = 1'b1;
                state_next = ST_CLR_WR;
            end
            ST_CLR_WR:
            begin
                cmd.clr_wr = 1'b1;
                state_next = sts.clr_last ? ST_DONE : ST_CLR_RD;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

/* sv/grc_datapath.sv */
module grc_datapath
    import grc_pkg::*;
#(
    parameter int COLUMNS = 64,
    parameter int ROWS    = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  grc_cmd_t    cmd,
    output grc_sts_t    sts,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic [5:0]  row_index,
    input  logic [63:0] row_bits,
    output logic        found,
    output logic        single_cell,
    output logic [5:0]  left,
    output logic [5:0]  top,
    output logic [5:0]  right,
    output logic [5:0]  bottom
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TW = ((RW > 7) ? RW : 7) + 1;

    logic [6:0]    act_cols_reg;
    logic [6:0]    act_rows_reg;
    logic [6:0]    cols_eff;
    logic [8:0]    rows_eff;

    logic [63:0]   mem [ROWS];
    logic [ROWS-1:0] valid_reg;
    logic [63:0]   rd_data_reg;
    logic [RW-1:0] rd_addr;
    logic          wr_en;
    logic [RW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic          load_ok;
    logic [63:0]   clr_mask;

    logic [6:0]    height_reg [COLUMNS];
    logic [6:0]    height_new [COLUMNS];
    logic [6:0]    depth_line_reg [COLUMNS];
    logic [6:0]    scan_line_reg [COLUMNS];

    logic [RW-1:0] i_reg;
    logic [RW-1:0] r_reg;
    logic [6:0]    c_reg;
    logic [6:0]    j_reg;
    logic [6:0]    d_reg;
    logic [6:0]    start_reg;
    logic          in_run_reg;

    logic [12:0]   best_area_reg;
    logic [5:0]    best_left_reg;
    logic [5:0]    best_right_reg;
    logic [RW-1:0] best_top_reg;
    logic [RW-1:0] best_bottom_reg;

    logic          seen;
    logic          tall;
    logic [6:0]    run_len;
    logic [13:0]   area;
    logic [RW-1:0] top_cand;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_cols_reg <= 7'd64;
            act_rows_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ACTIVE_COLUMNS)
            begin
                act_cols_reg <= cfg_data;
            end
            else
            begin
                act_rows_reg <= cfg_data;
            end
        end
    end

    assign cols_eff = (act_cols_reg > 7'(COLUMNS)) ? 7'(COLUMNS) : act_cols_reg;
    assign rows_eff = ({2'b00, act_rows_reg} > 9'(ROWS)) ? 9'(ROWS) : {2'b00, act_rows_reg};

    // bitmap store
    assign load_ok  = cmd.load && ({3'b000, row_index} < 9'(ROWS));
    assign wr_en    = load_ok || cmd.clr_wr;
    assign wr_addr  = cmd.clr_wr ? r_reg : RW'(row_index);
    assign clr_mask = ({64{1'b1}} << best_left_reg) & ({64{1'b1}} >> (6'd63 - best_right_reg));
    assign wr_data  = cmd.clr_wr ? (rd_data_reg & ~clr_mask) : row_bits;
    assign rd_addr  = cmd.clr_rd ? r_reg : i_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_data_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.row_rd || cmd.clr_rd)
            begin
                rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
            end
        end
    end

    // column heights and the two scan lines
    always_comb
    begin
        for (int k = 0; k < COLUMNS; k++)
        begin
            if (7'(k) >= cols_eff)
            begin
                height_new[k] = height_reg[k];
            end
            else if (rd_data_reg[k])
            begin
                height_new[k] = (height_reg[k] == HEIGHT_MAX) ? height_reg[k]
                                                              : height_reg[k] + 7'd1;
            end
            else
            begin
                height_new[k] = 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < COLUMNS; k++)
            begin
                height_reg[k]     <= 7'd0;
                depth_line_reg[k] <= 7'd0;
                scan_line_reg[k]  <= 7'd0;
            end
        end
        else
        begin
            for (int k = 0; k < COLUMNS; k++)
            begin
                if (cmd.init)
                begin
                    height_reg[k] <= 7'd0;
                end
                else if (cmd.height)
                begin
                    height_reg[k] <= height_new[k];
                end

                if (cmd.height)
                begin
                    depth_line_reg[k] <= height_new[k];
                end
                else if (cmd.outer_next)
                begin
                    depth_line_reg[k] <= (k == COLUMNS - 1) ? 7'd0 : depth_line_reg[(k + 1) % COLUMNS];
                end

                if (cmd.inner_load)
                begin
                    scan_line_reg[k] <= height_reg[k];
                end
                else if (cmd.inner_step)
                begin
                    scan_line_reg[k] <= (k == COLUMNS - 1) ? 7'd0 : scan_line_reg[(k + 1) % COLUMNS];
                end
            end
        end
    end

    // depth already seen to the left of the current column
    always_comb
    begin
        seen = 1'b0;
        for (int k = 0; k < COLUMNS; k++)
        begin
            if ((7'(k) < c_reg) && (height_reg[k] == depth_line_reg[0]))
            begin
                seen = 1'b1;
            end
        end
    end

    assign tall     = (j_reg < cols_eff) && (scan_line_reg[0] >= d_reg);
    assign run_len  = j_reg - start_reg;
    assign area     = {7'd0, run_len} * {7'd0, d_reg};
    assign top_cand = RW'(TW'(i_reg) + TW'(1) - TW'(d_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg           <= '0;
            r_reg           <= '0;
            c_reg           <= '0;
            j_reg           <= '0;
            d_reg           <= '0;
            start_reg       <= '0;
            in_run_reg      <= 1'b0;
            best_area_reg   <= '0;
            best_left_reg   <= '0;
            best_right_reg  <= '0;
            best_top_reg    <= '0;
            best_bottom_reg <= '0;
        end
        else
        begin
            if (cmd.init)
            begin
                i_reg           <= '0;
                best_area_reg   <= '0;
                best_left_reg   <= '0;
                best_right_reg  <= '0;
                best_top_reg    <= '0;
                best_bottom_reg <= '0;
            end
            else if (cmd.row_next)
            begin
                i_reg <= i_reg + RW'(1);
            end

            if (cmd.height)
            begin
                c_reg <= '0;
            end
            else if (cmd.outer_next)
            begin
                c_reg <= c_reg + 7'd1;
            end

            if (cmd.inner_load)
            begin
                j_reg      <= '0;
                d_reg      <= depth_line_reg[0];
                in_run_reg <= 1'b0;
            end
            else if (cmd.inner_step)
            begin
                j_reg <= j_reg + 7'd1;
                if (tall && !in_run_reg)
                begin
                    in_run_reg <= 1'b1;
                    start_reg  <= j_reg;
                end
                else if (!tall && in_run_reg)
                begin
                    in_run_reg <= 1'b0;
                    if (area > {1'b0, best_area_reg})
                    begin
                        best_area_reg   <= area[12:0];
                        best_left_reg   <= start_reg[5:0];
                        best_right_reg  <= 6'(j_reg - 7'd1);
                        best_top_reg    <= top_cand;
                        best_bottom_reg <= i_reg;
                    end
                end
            end

            if (cmd.clr_start)
            begin
                r_reg <= best_top_reg;
            end
            else if (cmd.clr_wr && !sts.clr_last)
            begin
                r_reg <= r_reg + RW'(1);
            end
        end
    end

    assign sts.empty_area = (cols_eff == 7'd0) || (rows_eff == 9'd0);
    assign sts.outer_end  = (c_reg == cols_eff);
    assign sts.depth_new  = (depth_line_reg[0] != 7'd0) && !seen;
    assign sts.row_last   = ((9'(i_reg) + 9'd1) == rows_eff);
    assign sts.inner_end  = (j_reg == cols_eff);
    assign sts.found      = (best_area_reg != 13'd0);
    assign sts.clr_last   = (r_reg == best_bottom_reg);

    assign found       = sts.found;
    assign single_cell = (best_left_reg == best_right_reg) && (best_top_reg == best_bottom_reg)
                         && sts.found;
    assign left        = best_left_reg;
    assign right       = best_right_reg;
    assign top         = 6'(best_top_reg);
    assign bottom      = 6'(best_bottom_reg);

endmodule

/* sv/greedy_rectangle_cover_extractor_core.sv */
// Holds a bitmap of up to ROWS rows by 64 bits. A beat with mode low writes
// one row in the accept cycle and gives no result; a beat with mode high
// searches for the largest all-ones rectangle, clears it and gives one
// result beat, marked by done for one cycle. The receiver cannot stall, so
// it must take the result in that cycle. Start is taken only while busy is
// low. For an extract, each row costs a read, a height update, a step per
// column and a wrap-up step; every distinct nonzero column height in a row
// adds a run scan across the columns, and the clearing pass takes a read
// and a write of the bitmap per rectangle row.
// The bitmap reads as all zeros after reset with no clearing pass.
module greedy_rectangle_cover_extractor_core
    import grc_pkg::*;
#(
    parameter int COLUMNS = 64,
    parameter int ROWS    = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [5:0]  row_index,
    input  logic [63:0] row_bits,
    output logic        done,
    output logic        found,
    output logic        single_cell,
    output logic [5:0]  left,
    output logic [5:0]  top,
    output logic [5:0]  right,
    output logic [5:0]  bottom,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

`include "greedy_rectangle_cover_extractor_core_assert.svh"

    grc_cmd_t cmd;
    grc_sts_t sts;

    // sequencer: row, depth and column loops plus the clearing pass
    grc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // bitmap store, heights, scan lines and best candidate
    grc_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .row_index   (row_index),
        .row_bits    (row_bits),
        .found       (found),
        .single_cell (single_cell),
        .left        (left),
        .top         (top),
        .right       (right),
        .bottom      (bottom)
    );

    // result strobe lasts one cycle
    `GRC_ASSERT_NXT(a_done_single, done, !done)
    // an extract beat always occupies the block
    `GRC_ASSERT_NXT(a_extract_busy, start && !busy && mode, busy)
    // a load beat completes in its accept cycle
    `GRC_ASSERT_NXT(a_load_free, start && !busy && !mode, !busy)
    // an empty result carries zero corners
    `GRC_ASSERT_IMP(a_empty_zero, done && !found,
        left == 6'd0 && top == 6'd0 && right == 6'd0 && bottom == 6'd0 && !single_cell)

endmodule
